### src/mafw_pkg.sv
package mafw_pkg;

  localparam int POS_BITS_DEFAULT = 32;
  localparam logic [31:0] SYNC_MASK_RESET = 32'hFFE0_0000;

  localparam logic [31:0] RATE_FIELD_MASK = 32'h0000_0C00;
  localparam logic [31:0] BR_FIELD_MASK   = 32'h0000_F000;
  localparam logic [31:0] PAD_FIELD_MASK  = 32'h0000_0200;
  localparam int RATE_FIELD_LSB = 10;
  localparam int BR_FIELD_LSB   = 12;
  localparam logic [10:0] HEADER_BYTES = 11'd4;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    CAUSE_CLEAN     = 2'd0,
    CAUSE_BAD_SYNC  = 2'd1,
    CAUSE_ZERO_SIZE = 2'd2,
    CAUSE_TRUNCATED = 2'd3
  } end_cause_t;

  typedef enum logic [1:0] {
    RATE_44K1     = 2'd0,
    RATE_48K      = 2'd1,
    RATE_32K      = 2'd2,
    RATE_RESERVED = 2'd3
  } rate_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [31:0]  header_word;
    logic [15:0]  sample_rate_hz;
    logic [8:0]   bit_rate_kbps;
    logic [10:0]  frame_length;
    logic [31:0]  frame_offset;
    logic [31:0]  total_bytes;
    end_cause_t   end_cause;
  } result_t;

  function automatic logic [15:0] sample_rate(input logic [1:0] code);
    logic [15:0] hz;
    case (code)
      RATE_44K1: hz = 16'd44100;
      RATE_48K:  hz = 16'd48000;
      RATE_32K:  hz = 16'd32000;
      default:   hz = 16'd0;
    endcase
    return hz;
  endfunction

  // layer iii, mpeg-1 bit rates; free and bad codes read as zero
  function automatic logic [8:0] bit_rate(input logic [3:0] code);
    logic [8:0] kbps;
    case (code)
      4'd1:    kbps = 9'd32;
      4'd2:    kbps = 9'd40;
      4'd3:    kbps = 9'd48;
      4'd4:    kbps = 9'd56;
      4'd5:    kbps = 9'd64;
      4'd6:    kbps = 9'd80;
      4'd7:    kbps = 9'd96;
      4'd8:    kbps = 9'd112;
      4'd9:    kbps = 9'd128;
      4'd10:   kbps = 9'd160;
      4'd11:   kbps = 9'd192;
      4'd12:   kbps = 9'd224;
      4'd13:   kbps = 9'd256;
      4'd14:   kbps = 9'd320;
      default: kbps = 9'd0;
    endcase
    return kbps;
  endfunction

  // floor(144000 * kbps / rate), zero for any unusable code, no padding
  function automatic logic [10:0] frame_bytes(input logic [1:0] rcode,
                                              input logic [3:0] bcode);
    logic [10:0] n44;
    logic [10:0] n48;
    logic [10:0] n32;
    logic [10:0] n;
    case (bcode)
      4'd1:    begin n44 = 11'd104;  n48 = 11'd96;  n32 = 11'd144;  end
      4'd2:    begin n44 = 11'd130;  n48 = 11'd120; n32 = 11'd180;  end
      4'd3:    begin n44 = 11'd156;  n48 = 11'd144; n32 = 11'd216;  end
      4'd4:    begin n44 = 11'd182;  n48 = 11'd168; n32 = 11'd252;  end
      4'd5:    begin n44 = 11'd208;  n48 = 11'd192; n32 = 11'd288;  end
      4'd6:    begin n44 = 11'd261;  n48 = 11'd240; n32 = 11'd360;  end
      4'd7:    begin n44 = 11'd313;  n48 = 11'd288; n32 = 11'd432;  end
      4'd8:    begin n44 = 11'd365;  n48 = 11'd336; n32 = 11'd504;  end
      4'd9:    begin n44 = 11'd417;  n48 = 11'd384; n32 = 11'd576;  end
      4'd10:   begin n44 = 11'd522;  n48 = 11'd480; n32 = 11'd720;  end
      4'd11:   begin n44 = 11'd626;  n48 = 11'd576; n32 = 11'd864;  end
      4'd12:   begin n44 = 11'd731;  n48 = 11'd672; n32 = 11'd1008; end
      4'd13:   begin n44 = 11'd835;  n48 = 11'd768; n32 = 11'd1152; end
      4'd14:   begin n44 = 11'd1044; n48 = 11'd960; n32 = 11'd1440; end
      default: begin n44 = 11'd0;    n48 = 11'd0;   n32 = 11'd0;    end
    endcase
    case (rcode)
      RATE_44K1: n = n44;
      RATE_48K:  n = n48;
      RATE_32K:  n = n32;
      default:   n = 11'd0;
    endcase
    return n;
  endfunction

endpackage

### src/mpeg_audio_frame_walker.sv
// mpeg audio frame walker: takes an mp3 byte stream one word (one byte plus a
// last-byte mark) per cycle, gathers the 4-byte big-endian header at each frame
// position, checks it against sync_mask, decodes sample rate and bit rate, looks
// the frame size up in a constant table (plus the padding byte) and skips the
// frame body. each good header not on the final byte gives a frame report; the
// final byte always gives a summary with the total size of complete frames and
// the stop cause, after which the walker is back at reset for the next stream
// (sync_mask is kept). throughput is one byte per cycle unless stalled: all work
// for a byte is one pass of logic from the walk state registers into the result
// register, so a result shows in the cycle after its byte is taken. item_stall
// rises only when a byte that would produce a result meets a full result
// register that is itself stalled; bytes without a result keep flowing. cfg_ready
// is always high and sync_mask should be written only while the walker is idle.
module mpeg_audio_frame_walker #(
  parameter int POS_BITS = mafw_pkg::POS_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // byte input
  input  logic             item_valid,
  output logic             item_stall,
  input  mafw_pkg::item_t  item,
  // report output
  output logic             result_valid,
  input  logic             result_stall,
  output mafw_pkg::result_t result,
  // sync mask write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  localparam int ExtBits = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int RATE_FIELD_LSB_HI = mafw_pkg::RATE_FIELD_LSB + 1;
  localparam int BR_FIELD_LSB_HI   = mafw_pkg::BR_FIELD_LSB + 3;

  // walk state
  logic [31:0]         sync_mask;
  logic [POS_BITS-1:0] stream_position;
  logic [31:0]         header_shift;
  logic [1:0]          header_byte_count;
  logic [10:0]         skip_remaining;
  logic [10:0]         current_size;
  logic [31:0]         running_total;
  logic                walk_stopped;
  mafw_pkg::end_cause_t stop_reason;

  logic [POS_BITS-1:0] stream_position_next;
  logic [31:0]         header_shift_next;
  logic [1:0]          header_byte_count_next;
  logic [10:0]         skip_remaining_next;
  logic [10:0]         current_size_next;
  logic [31:0]         running_total_next;
  logic                walk_stopped_next;
  mafw_pkg::end_cause_t stop_reason_next;

  mafw_pkg::result_t   result_next;
  logic                produces;
  logic                accept;

  assign cfg_ready = 1'b1;

  // stall only a byte that actually needs the result register
  assign item_stall = result_valid & result_stall & produces;
  assign accept     = item_valid & ~item_stall;

  always_comb begin
    logic [31:0]         hdr;
    logic [1:0]          rcode;
    logic [3:0]          bcode;
    logic [10:0]         size;
    logic [POS_BITS-1:0] start_pos;
    logic [ExtBits-1:0]  start_ext;
    logic                emit_frame;

    stream_position_next   = stream_position + POS_BITS'(1);
    header_shift_next      = header_shift;
    header_byte_count_next = header_byte_count;
    skip_remaining_next    = skip_remaining;
    current_size_next      = current_size;
    running_total_next     = running_total;
    walk_stopped_next      = walk_stopped;
    stop_reason_next       = stop_reason;
    emit_frame             = 1'b0;

    hdr   = {header_shift[23:0], item.data_byte};
    rcode = hdr[RATE_FIELD_LSB_HI:mafw_pkg::RATE_FIELD_LSB];
    bcode = hdr[BR_FIELD_LSB_HI:mafw_pkg::BR_FIELD_LSB];
    size  = mafw_pkg::frame_bytes(rcode, bcode);
    if (size != 11'd0 && (hdr & mafw_pkg::PAD_FIELD_MASK) != 32'd0) begin
      size = size + 11'd1;
    end

    start_pos = stream_position - POS_BITS'(3);
    start_ext = ExtBits'(start_pos);

    if (!walk_stopped) begin
      if (skip_remaining != 11'd0) begin
        // inside a frame body: count down, book the frame on its last byte
        skip_remaining_next = skip_remaining - 11'd1;
        if (skip_remaining == 11'd1) begin
          running_total_next = running_total + 32'(current_size);
        end
      end else begin
        header_shift_next = hdr;
        if (header_byte_count == 2'd3) begin
          header_byte_count_next = 2'd0;
          if ((hdr & sync_mask) != sync_mask) begin
            walk_stopped_next = 1'b1;
            stop_reason_next  = mafw_pkg::CAUSE_BAD_SYNC;
          end else if (size == 11'd0) begin
            // free, bad or reserved code
            walk_stopped_next = 1'b1;
            stop_reason_next  = mafw_pkg::CAUSE_ZERO_SIZE;
          end else begin
            current_size_next   = size;
            skip_remaining_next = size - mafw_pkg::HEADER_BYTES;
            emit_frame          = ~item.last_byte;
          end
        end else begin
          header_byte_count_next = header_byte_count + 2'd1;
        end
      end
    end

    // frame report
    result_next                = '0;
    result_next.result_kind    = mafw_pkg::KIND_FRAME;
    result_next.header_word    = hdr;
    result_next.sample_rate_hz = mafw_pkg::sample_rate(rcode);
    result_next.bit_rate_kbps  = mafw_pkg::bit_rate(bcode);
    result_next.frame_length   = size;
    result_next.frame_offset   = start_ext[31:0];
    result_next.total_bytes    = '0;
    result_next.end_cause      = mafw_pkg::CAUSE_CLEAN;

    if (item.last_byte) begin
      // summary sees the state after this byte, then the walk restarts
      result_next             = '0;
      result_next.result_kind = mafw_pkg::KIND_SUMMARY;
      result_next.total_bytes = running_total_next;
      if (walk_stopped_next) begin
        result_next.end_cause = stop_reason_next;
      end else if (header_byte_count_next != 2'd0) begin
        result_next.end_cause = mafw_pkg::CAUSE_TRUNCATED;
      end else begin
        result_next.end_cause = mafw_pkg::CAUSE_CLEAN;
      end
      stream_position_next   = '0;
      header_shift_next      = '0;
      header_byte_count_next = '0;
      skip_remaining_next    = '0;
      current_size_next      = '0;
      running_total_next     = '0;
      walk_stopped_next      = 1'b0;
      stop_reason_next       = mafw_pkg::CAUSE_CLEAN;
    end

    produces = emit_frame | item.last_byte;
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position   <= '0;
      header_shift      <= '0;
      header_byte_count <= '0;
      skip_remaining    <= '0;
      current_size      <= '0;
      running_total     <= '0;
      walk_stopped      <= 1'b0;
      stop_reason       <= mafw_pkg::CAUSE_CLEAN;
    end else if (accept) begin
      stream_position   <= stream_position_next;
      header_shift      <= header_shift_next;
      header_byte_count <= header_byte_count_next;
      skip_remaining    <= skip_remaining_next;
      current_size      <= current_size_next;
      running_total     <= running_total_next;
      walk_stopped      <= walk_stopped_next;
      stop_reason       <= stop_reason_next;
    end
  end

  // sync mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mask <= mafw_pkg::SYNC_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_mask <= cfg_data;
    end
  end

  // result register: load on a producing byte, drain when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && produces) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produces) begin
      result <= result_next;
    end
  end

  // the last byte always leaves a clean walk behind
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> stream_position == '0 && !walk_stopped
      && running_total == 32'd0)
    else $error("walk not restarted after last byte");

  // a stopped walk never sits inside a frame body
  a_stop_no_skip: assert property (@(posedge clk) disable iff (rst)
    walk_stopped |-> skip_remaining == 11'd0)
    else $error("stopped walk with pending skip");

  // header gathering and body skipping never overlap
  a_skip_aligned: assert property (@(posedge clk) disable iff (rst)
    skip_remaining != 11'd0 |-> header_byte_count == 2'd0)
    else $error("skip active mid-header");

  // frame reports carry a real size and no summary fields
  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == mafw_pkg::KIND_FRAME
      |-> result.frame_length != 11'd0 && result.total_bytes == 32'd0)
    else $error("malformed frame report");

endmodule

### verif/mafw_checker.sv
`timescale 1ns / 1ps
module mafw_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  mafw_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  mafw_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam int MAX_REPORTS = 10;

  // layer iii bit rates in kbit/s, free and bad codes as zero
  logic [8:0] kbps_by_code [0:15] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
                                      9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224,
                                      9'd256, 9'd320, 9'd0};

  logic [31:0] sync_bits = mafw_pkg::SYNC_MASK_RESET;
  logic [31:0] byte_pos = '0;
  logic [31:0] hdr_acc = '0;
  logic [2:0]  hdr_count = '0;
  logic [10:0] skip_left = '0;
  logic [10:0] frame_len = '0;
  logic [31:0] frame_total = '0;
  bit          halted = 1'b0;
  mafw_pkg::end_cause_t halt_cause = mafw_pkg::CAUSE_CLEAN;
  mafw_pkg::result_t    due_q[$];
  int          n_fail = 0;

  function automatic int unsigned rate_hz(input logic [31:0] hdr);
    logic [1:0] code;
    int unsigned hz;
    code = 2'((hdr & mafw_pkg::RATE_FIELD_MASK) >> mafw_pkg::RATE_FIELD_LSB);
    case (mafw_pkg::rate_code_t'(code))
      mafw_pkg::RATE_44K1: hz = 44100;
      mafw_pkg::RATE_48K:  hz = 48000;
      mafw_pkg::RATE_32K:  hz = 32000;
      default:             hz = 0;
    endcase
    return hz;
  endfunction

  function automatic logic [8:0] kbps_of(input logic [31:0] hdr);
    return kbps_by_code[4'((hdr & mafw_pkg::BR_FIELD_MASK) >> mafw_pkg::BR_FIELD_LSB)];
  endfunction

  // bytes in the whole frame, zero when the header is unusable
  function automatic int unsigned span_of(input logic [31:0] hdr);
    int unsigned kbps;
    int unsigned hz;
    kbps = kbps_of(hdr);
    hz = rate_hz(hdr);
    if (kbps == 0 || hz == 0)
      return 0;
    return (144 * kbps * 1000) / hz + (((hdr & mafw_pkg::PAD_FIELD_MASK) != 0) ? 1 : 0);
  endfunction

  function automatic string describe(input mafw_pkg::result_t r);
    return $sformatf("kind %0d hdr %h rate %0d kbps %0d size %0d offset %h total %0d cause %0d",
                     r.result_kind, r.header_word, r.sample_rate_hz, r.bit_rate_kbps,
                     r.frame_length, r.frame_offset, r.total_bytes, r.end_cause);
  endfunction

  task automatic restart_walk();
    byte_pos = '0;
    hdr_acc = '0;
    hdr_count = '0;
    skip_left = '0;
    frame_len = '0;
    frame_total = '0;
    halted = 1'b0;
    halt_cause = mafw_pkg::CAUSE_CLEAN;
  endtask

  task automatic walk_byte(input mafw_pkg::item_t it);
    mafw_pkg::result_t r;
    logic [31:0] here;
    logic [31:0] hdr;
    int unsigned span;
    bit emit;
    r = '0;
    emit = 1'b0;
    here = byte_pos;
    if (!halted) begin
      if (skip_left != 0) begin
        skip_left = skip_left - 11'd1;
        if (skip_left == 0)
          frame_total = frame_total + 32'(frame_len);
      end else begin
        hdr_acc = {hdr_acc[23:0], it.data_byte};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= 3'd4) begin
          hdr = hdr_acc;
          hdr_count = '0;
          span = span_of(hdr);
          if ((hdr & sync_bits) != sync_bits) begin
            halted = 1'b1;
            halt_cause = mafw_pkg::CAUSE_BAD_SYNC;
          end else if (span == 0) begin
            halted = 1'b1;
            halt_cause = mafw_pkg::CAUSE_ZERO_SIZE;
          end else begin
            frame_len = 11'(span);
            skip_left = 11'(span - 4);
            if (!it.last_byte) begin
              r.result_kind = mafw_pkg::KIND_FRAME;
              r.header_word = hdr;
              r.sample_rate_hz = 16'(rate_hz(hdr));
              r.bit_rate_kbps = kbps_of(hdr);
              r.frame_length = frame_len;
              r.frame_offset = here - 32'd3;
              emit = 1'b1;
            end
          end
        end
      end
    end
    byte_pos = byte_pos + 32'd1;
    if (it.last_byte) begin
      r = '0;
      r.result_kind = mafw_pkg::KIND_SUMMARY;
      r.total_bytes = frame_total;
      if (halted)
        r.end_cause = halt_cause;
      else if (hdr_count != 0)
        r.end_cause = mafw_pkg::CAUSE_TRUNCATED;
      else
        r.end_cause = mafw_pkg::CAUSE_CLEAN;
      emit = 1'b1;
      restart_walk();
    end
    if (emit)
      due_q.push_back(r);
  endtask

  task automatic check_result(input mafw_pkg::result_t got);
    mafw_pkg::result_t want;
    if (due_q.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: result word with nothing due: %s", $time, describe(got));
    end else begin
      want = due_q.pop_front();
      if (got.result_kind !== want.result_kind || got.header_word !== want.header_word ||
          got.sample_rate_hz !== want.sample_rate_hz ||
          got.bit_rate_kbps !== want.bit_rate_kbps || got.frame_length !== want.frame_length ||
          got.frame_offset !== want.frame_offset || got.total_bytes !== want.total_bytes ||
          got.end_cause !== want.end_cause) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_bits = mafw_pkg::SYNC_MASK_RESET;
      restart_walk();
      due_q.delete();
      n_fail = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        sync_bits = cfg_data;
      // a result taken at this edge comes from a byte taken earlier
      if (result_valid && !result_stall)
        check_result(result);
      if (item_valid && !item_stall)
        walk_byte(item);
    end
    fail_count <= n_fail;
    pending <= due_q.size();
  end

endmodule

### verif/tb_mpeg_audio_frame_walker.sv
`timescale 1ns / 1ps
module tb_mpeg_audio_frame_walker;

  // run shape
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 1850;
  // a result shows in the cycle after its byte, so this settle time is plenty
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 5;

  // how a generated stream ends
  typedef enum int {
    SHAPE_CLEAN,
    SHAPE_CUT,
    SHAPE_PARTIAL,
    SHAPE_BAD_SYNC,
    SHAPE_ZERO_SIZE,
    SHAPE_HDR_AT_END,
    SHAPE_NOISE
  } stream_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  mafw_pkg::item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  mafw_pkg::result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;

  // bytes that the walker acts on; bytes after a stop are not counted
  int          bytes_sent = 0;
  // sync mask currently loaded, used to build headers that pass or fail
  logic [31:0] mask_now = mafw_pkg::SYNC_MASK_RESET;
  // long hold request from stimulus to the result sink
  bit          hold_req = 1'b0;
  bit          no_gap = 1'b0;
  // force the shortest frames so the result register backs up quickly
  bit          tiny_frames = 1'b0;
  logic [7:0]  stream_q[$];

  mpeg_audio_frame_walker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  mafw_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("mpeg_audio_frame_walker test failed");
    $finish;
  end

  // result sink: random stall before each word, quiet stretches, one long hold
  initial begin : result_sink
    int unsigned wait_n;
    int quiet_left;
    quiet_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold so reports pile up and the byte input backs up
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (quiet_left > 0)
          quiet_left--;
        else if ($urandom_range(0, 15) == 0)
          quiet_left = 24;
        wait_n = (quiet_left > 0) ? 0 : $urandom_range(0, 9);
        if (wait_n != 0) begin
          result_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // one byte word, random gap in front unless a burst is running
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item.data_byte <= data;
    item.last_byte <= last;
    do @(posedge clk); while (item_stall);
  endtask

  // send the queued stream with the last-byte mark on its final byte
  task automatic play_stream(input int ignored);
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    bytes_sent += stream_q.size() - ignored;
    stream_q.delete();
  endtask

  // big-endian header bytes
  task automatic push_header(input logic [31:0] w);
    for (int k = 3; k >= 0; k--)
      stream_q.push_back(w[8*k +: 8]);
  endtask

  task automatic push_body(input int n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // wait until every expected word is in, then let the walker settle
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_mask(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mask_now = v;
  endtask

  // stream length of a header, zero when it cannot form a frame
  function automatic int frame_span(input logic [31:0] w);
    logic [10:0] n;
    n = mafw_pkg::frame_bytes(
          2'((w & mafw_pkg::RATE_FIELD_MASK) >> mafw_pkg::RATE_FIELD_LSB),
          4'((w & mafw_pkg::BR_FIELD_MASK) >> mafw_pkg::BR_FIELD_LSB));
    if (n == 0)
      return 0;
    return int'(n) + (((w & mafw_pkg::PAD_FIELD_MASK) != 0) ? 1 : 0);
  endfunction

  // header that passes the loaded mask; mostly low bit rates to keep frames short
  function automatic logic [31:0] good_header();
    logic [1:0]  rcode;
    logic [3:0]  bcode;
    logic [31:0] w;
    if (tiny_frames) begin
      rcode = mafw_pkg::RATE_48K;
      bcode = 4'd1;
    end else begin
      rcode = 2'($urandom_range(0, 2));
      bcode = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 14))
                                          : 4'($urandom_range(1, 5));
    end
    w = $urandom & ~(mafw_pkg::RATE_FIELD_MASK | mafw_pkg::BR_FIELD_MASK |
                     mafw_pkg::PAD_FIELD_MASK);
    w = w | (32'(rcode) << mafw_pkg::RATE_FIELD_LSB) |
        (32'(bcode) << mafw_pkg::BR_FIELD_LSB);
    if ($urandom_range(0, 1) == 1)
      w = w | mafw_pkg::PAD_FIELD_MASK;
    return w | mask_now;
  endfunction

  // in sync but unusable: bad bit rate, reserved rate or free bit rate
  function automatic logic [31:0] zero_header();
    logic [31:0] w;
    w = good_header();
    case ($urandom_range(0, 2))
      0:       w = w | mafw_pkg::BR_FIELD_MASK;
      1:       w = w | mafw_pkg::RATE_FIELD_MASK;
      default: w = (w & ~mafw_pkg::BR_FIELD_MASK) | mask_now;
    endcase
    // mask bits may keep a free code from sticking
    if (frame_span(w) != 0)
      w = w | mafw_pkg::BR_FIELD_MASK;
    return w;
  endfunction

  // one mask bit knocked out; only called with a nonzero mask
  function automatic logic [31:0] bad_header();
    logic [31:0] w;
    int unsigned idx;
    w = good_header();
    do idx = $urandom_range(0, 31); while (!mask_now[idx]);
    w[idx] = 1'b0;
    return w;
  endfunction

  function automatic stream_shape_t pick_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return SHAPE_CLEAN;
    if (r < 45) return SHAPE_CUT;
    if (r < 55) return SHAPE_PARTIAL;
    if (r < 65) return SHAPE_BAD_SYNC;
    if (r < 75) return SHAPE_ZERO_SIZE;
    if (r < 85) return SHAPE_HDR_AT_END;
    return SHAPE_NOISE;
  endfunction

  // build one stream of whole frames and then the chosen ending
  task automatic send_stream(input stream_shape_t shape, input int nframes);
    logic [31:0] w;
    int span;
    int ignored;
    bit halted;
    ignored = 0;
    halted = 1'b0;
    if (shape == SHAPE_NOISE)
      push_body($urandom_range(1, 12));
    for (int f = 0; f < nframes && !halted; f++) begin
      w = good_header();
      span = frame_span(w);
      push_header(w);
      if (span == 0) begin
        // the mask forced an unusable code, the walk stops here
        halted = 1'b1;
        ignored = $urandom_range(0, 4);
        push_body(ignored + 1);
      end else if (f == nframes - 1 && shape == SHAPE_CUT) begin
        push_body($urandom_range(1, span - 5));
      end else begin
        push_body(span - 4);
      end
    end
    if (!halted) begin
      case (shape)
        SHAPE_PARTIAL: push_body($urandom_range(1, 3));
        SHAPE_BAD_SYNC, SHAPE_ZERO_SIZE: begin
          if (shape == SHAPE_BAD_SYNC && mask_now != 0)
            push_header(bad_header());
          else
            push_header(zero_header());
          // bytes after a stop are dropped until the final one
          ignored = $urandom_range(0, 5);
          push_body(ignored + 1);
        end
        SHAPE_HDR_AT_END: begin
          // header completed by the final byte
          case ($urandom_range(0, 2))
            0:       w = zero_header();
            1:       w = (mask_now != 0) ? bad_header() : zero_header();
            default: w = good_header();
          endcase
          push_header(w);
        end
        default: ;
      endcase
    end
    if (stream_q.size() == 0)
      push_body(1);
    play_stream(ignored);
  endtask

  initial begin : stimulus
    logic [31:0] mask_plan [PHASES];
    int phase_end [PHASES];
    stream_shape_t shape;
    bit paused;

    paused = 1'b0;
    mask_plan[0] = mafw_pkg::SYNC_MASK_RESET;
    mask_plan[1] = 32'h0000_0000;
    // random mask kept off the rate and bit rate fields so frames still occur
    mask_plan[2] = $urandom & ~(mafw_pkg::RATE_FIELD_MASK | mafw_pkg::BR_FIELD_MASK);
    mask_plan[3] = 32'hFFFF_FFFF;
    mask_plan[4] = mafw_pkg::SYNC_MASK_RESET | 32'h0001_0000;
    phase_end[0] = 500;
    phase_end[1] = 900;
    phase_end[2] = 1200;
    phase_end[3] = 1260;
    phase_end[4] = ITEM_TARGET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed streams, reset value of the mask
    // bit rate code 12 reads as 224, padded, then the stream is cut off
    push_header(32'hFFFB_C2C4);
    stream_q.push_back(8'h00);
    play_stream(0);
    // bad bit rate code, zero size, trailing byte ignored
    push_header(32'hFFFB_F800);
    stream_q.push_back(8'hFF);
    play_stream(0);
    // all-zero header fails sync
    push_header(32'h0000_0000);
    stream_q.push_back(8'h55);
    play_stream(0);
    // partial header at the end
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'hAA);
    play_stream(0);
    // good header on the final byte gives only the summary
    push_header(32'hFFFB_E6FF);
    play_stream(0);
    // reserved rate code on the final byte
    push_header(32'hFFFB_1C00);
    play_stream(0);
    // lone byte
    stream_q.push_back(8'h00);
    play_stream(0);

    for (int p = 0; p < PHASES; p++) begin
      load_mask(mask_plan[p]);
      if (p == 0) begin
        // back-to-back short frames against a long receiver hold
        hold_req = 1'b1;
        tiny_frames = 1'b1;
        no_gap = 1'b1;
        send_stream(SHAPE_CLEAN, 4);
        tiny_frames = 1'b0;
      end
      while (bytes_sent < phase_end[p]) begin
        if (p == 1 && !paused && bytes_sent >= 700) begin
          // sender pauses until everything is back
          drain();
          paused = 1'b1;
        end
        no_gap = ($urandom_range(0, 3) == 0);
        shape = pick_shape();
        if (shape == SHAPE_CLEAN || shape == SHAPE_CUT)
          send_stream(shape, $urandom_range(1, 3));
        else
          send_stream(shape, $urandom_range(0, 2));
      end
    end

    drain();
    if (fail_count == 0)
      $display("mpeg_audio_frame_walker test passed");
    else
      $display("mpeg_audio_frame_walker test failed");
    $finish;
  end

endmodule

### files.f
src/mafw_pkg.sv
src/mpeg_audio_frame_walker.sv
verif/mafw_checker.sv
verif/tb_mpeg_audio_frame_walker.sv
